/* rtl/core/ets_pkg.sv */
// Package for the exhaustive tour search block: sizes, state codes and the
// command and status groups between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ets_pkg;

   // Sizing of the search.
   localparam int MAX_CITIES  = 8;
   localparam int DIST_BITS   = 16;

   // Fixed widths of the channel fields and of the register.
   localparam int DIST_IN_BITS   = 16;
   localparam int CITY_OUT_BITS  = 3;
   localparam int TOUR_COST_BITS = 19;
   localparam int CFG_BITS       = 4;
   localparam int CITY_COUNT_RESET = 4;

   // Derived widths.
   localparam int CITY_BITS   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int CNT_BITS    = $clog2(MAX_CITIES + 1);
   localparam int STORE_DEPTH = MAX_CITIES * MAX_CITIES;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int LOAD_BITS   = $clog2(STORE_DEPTH + 1);
   localparam int PROD_BITS   = 2 * CNT_BITS;
   localparam int COST_BITS   = DIST_BITS + CITY_BITS + 1;

   // Best cost before any order of a job has been scored.
   localparam logic [COST_BITS-1:0] COST_ALL_ONES = '1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ENTER,
      ST_EVAL,
      ST_DRAIN,
      ST_COMPARE,
      ST_UNDO,
      ST_ADVANCE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic store;      // write the accepted distance beat
      logic start;      // begin a new search
      logic enter;      // open the next level of the order tree
      logic issue;      // read one edge of the current order
      logic compare;    // score the finished order
      logic up;         // return to the level above
      logic undo;       // swap back and step the choice at this level
      logic advance;    // apply the new choice at this level and go deeper
      logic emit_next;  // one tour city was taken
   } cmd_type;

   typedef struct packed {
      logic leaf;         // the current level is the last position
      logic last_edge;    // the edge being read closes the cycle
      logic depth_zero;   // at the top level
      logic more_choices; // the current level has another city to try
      logic last_out;     // the city being shown is the last of the tour
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/ets_if.sv */
// Channel interfaces of the exhaustive tour search: distance beats in,
// tour beats out, and the city count write port. Depends on ets_pkg.
`default_nettype none

interface ets_req_if;
   import ets_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [DIST_IN_BITS-1:0] distance;
   logic                    last_entry;
   modport source (output valid, output distance, output last_entry, input ready);
   modport sink (input valid, input distance, input last_entry, output ready);
endinterface

interface ets_rsp_if;
   import ets_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CITY_OUT_BITS-1:0]  city;
   logic [TOUR_COST_BITS-1:0] tour_cost;
   logic                      last_city;
   modport source (output valid, output city, output tour_cost, output last_city,
                   input ready);
   modport sink (input valid, input city, input tour_cost, input last_city,
                 output ready);
endinterface

interface ets_csr_if;
   import ets_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] city_count;
   modport source (output valid, output city_count, input ready);
   modport sink (input valid, input city_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/ets_ctrl.sv */
// Controller of the exhaustive tour search: walks the order tree and
// sequences loading, scoring and tour output. Depends on ets_pkg.
`default_nettype none

module ets_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire                      req_last_entry,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   input  ets_pkg::status_type      status,
   output ets_pkg::cmd_type         cmd
);
   import ets_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last_entry) begin
                  cmd.start = 1'b1;
                  state_in  = ST_ENTER;
               end
            end
         end
         ST_ENTER: begin
            if (status.leaf) begin
               state_in = ST_EVAL;
            end else begin
               cmd.enter = 1'b1;
            end
         end
         ST_EVAL: begin
            cmd.issue = 1'b1;
            if (status.last_edge) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            if (status.depth_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.up   = 1'b1;
               state_in = ST_UNDO;
            end
         end
         ST_UNDO: begin
            cmd.undo = 1'b1;
            if (status.more_choices) begin
               state_in = ST_ADVANCE;
            end else if (status.depth_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.up = 1'b1;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_ENTER;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_next = 1'b1;
               if (status.last_out) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/ets_datapath.sv */
// Datapath of the exhaustive tour search: distance memory, current order with
// its level stack, cost accumulator, best tour and the city count register.
// Depends on ets_pkg.
`default_nettype none

module ets_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  ets_pkg::cmd_type                    cmd,
   output ets_pkg::status_type                 status,
   input  wire [ets_pkg::DIST_IN_BITS-1:0]     req_distance,
   input  wire                                 csr_valid,
   input  wire [ets_pkg::CFG_BITS-1:0]         csr_city_count,
   output logic [ets_pkg::CITY_OUT_BITS-1:0]   rsp_city,
   output logic [ets_pkg::TOUR_COST_BITS-1:0]  rsp_tour_cost,
   output logic                                rsp_last_city
);
   import ets_pkg::*;

   logic [DIST_BITS-1:0] dist_mem [STORE_DEPTH];
   logic [DIST_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   logic [CFG_BITS-1:0]  city_count_ff, city_count_in;
   logic [LOAD_BITS-1:0] load_pos_ff, load_pos_in;
   logic [CITY_BITS-1:0] order_ff [MAX_CITIES];
   logic [CITY_BITS-1:0] order_in [MAX_CITIES];
   logic [CNT_BITS-1:0]  level_ff [MAX_CITIES];
   logic [CNT_BITS-1:0]  level_in [MAX_CITIES];
   logic [CITY_BITS-1:0] best_order_ff [MAX_CITIES];
   logic [CITY_BITS-1:0] best_order_in [MAX_CITIES];
   logic [COST_BITS-1:0] best_cost_ff, best_cost_in;
   logic                 best_valid_ff, best_valid_in;
   logic [COST_BITS-1:0] acc_ff, acc_in;
   logic [CITY_BITS-1:0] depth_ff, depth_in;
   logic [CITY_BITS-1:0] edge_ff, edge_in;
   logic [CITY_BITS-1:0] emit_ff, emit_in;

   logic [CNT_BITS-1:0]  n_eff;
   logic [CITY_BITS-1:0] choice;
   logic [CNT_BITS-1:0]  level_cur;
   logic [CITY_BITS-1:0] edge_nx;
   logic [CITY_BITS-1:0] city_a;
   logic [CITY_BITS-1:0] city_b;
   logic [PROD_BITS-1:0] rd_sum;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 store_ok;
   logic                 better;

   // City count in use: zero means one city, large values saturate.
   always_comb begin
      if (city_count_ff == '0) begin
         n_eff = CNT_BITS'(1);
      end else if (city_count_ff > CFG_BITS'(MAX_CITIES)) begin
         n_eff = CNT_BITS'(MAX_CITIES);
      end else begin
         n_eff = CNT_BITS'(city_count_ff);
      end
   end

   assign level_cur = level_ff[depth_ff];
   assign choice    = CITY_BITS'(level_cur);

   assign status.leaf         = (CNT_BITS'(depth_ff) + CNT_BITS'(1)) >= n_eff;
   assign status.last_edge    = (CNT_BITS'(edge_ff) + CNT_BITS'(1)) == n_eff;
   assign status.depth_zero   = (depth_ff == '0);
   assign status.more_choices = (level_cur + CNT_BITS'(1)) < n_eff;
   assign status.last_out     = (CNT_BITS'(emit_ff) + CNT_BITS'(1)) == n_eff;

   // Edge address: entry (a, b) lives at a * n + b.
   assign edge_nx = status.last_edge ? '0 : edge_ff + CITY_BITS'(1);
   assign city_a  = order_ff[edge_ff];
   assign city_b  = order_ff[edge_nx];
   assign rd_sum  = PROD_BITS'(city_a) * PROD_BITS'(n_eff) + PROD_BITS'(city_b);
   assign rd_addr = rd_sum[ADDR_BITS-1:0];

   assign store_ok = cmd.store && (load_pos_ff < LOAD_BITS'(STORE_DEPTH));
   assign better   = !best_valid_ff || (acc_ff < best_cost_ff);

   always_ff @(posedge clock) begin
      if (store_ok) begin
         dist_mem[load_pos_ff[ADDR_BITS-1:0]] <= DIST_BITS'(req_distance);
      end
      rd_data_ff <= dist_mem[rd_addr];
   end

   always_comb begin
      city_count_in = csr_valid ? csr_city_count : city_count_ff;

      load_pos_in = load_pos_ff;
      if (cmd.start) begin
         load_pos_in = '0;
      end else if (store_ok) begin
         load_pos_in = load_pos_ff + LOAD_BITS'(1);
      end

      order_in      = order_ff;
      level_in      = level_ff;
      best_order_in = best_order_ff;
      if (cmd.start) begin
         for (int i = 0; i < MAX_CITIES; i++) begin
            order_in[i] = CITY_BITS'(i);
            level_in[i] = '0;
         end
      end
      if (cmd.undo || cmd.advance) begin
         order_in[depth_ff] = order_ff[choice];
         order_in[choice]   = order_ff[depth_ff];
      end
      if (cmd.enter) begin
         level_in[depth_ff] = CNT_BITS'(depth_ff);
      end
      if (cmd.undo) begin
         level_in[depth_ff] = status.more_choices ? level_cur + CNT_BITS'(1) : '0;
      end
      if (cmd.compare && better) begin
         best_order_in = order_ff;
      end

      best_cost_in  = best_cost_ff;
      best_valid_in = best_valid_ff;
      if (cmd.start) begin
         best_cost_in  = COST_ALL_ONES;
         best_valid_in = 1'b0;
      end else if (cmd.compare && better) begin
         best_cost_in  = acc_ff;
         best_valid_in = 1'b1;
      end

      acc_in = acc_ff;
      if (cmd.start || cmd.compare) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + COST_BITS'(rd_data_ff);
      end

      depth_in = depth_ff;
      if (cmd.start) begin
         depth_in = '0;
      end else if (cmd.enter || cmd.advance) begin
         depth_in = depth_ff + CITY_BITS'(1);
      end else if (cmd.up) begin
         depth_in = depth_ff - CITY_BITS'(1);
      end

      edge_in = edge_ff;
      if (cmd.start) begin
         edge_in = '0;
      end else if (cmd.issue) begin
         edge_in = edge_nx;
      end

      emit_in = emit_ff;
      if (cmd.start) begin
         emit_in = '0;
      end else if (cmd.emit_next) begin
         emit_in = status.last_out ? '0 : emit_ff + CITY_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= CFG_BITS'(CITY_COUNT_RESET);
         load_pos_ff   <= '0;
         best_cost_ff  <= COST_ALL_ONES;
         best_valid_ff <= 1'b0;
         acc_ff        <= '0;
         depth_ff      <= '0;
         edge_ff       <= '0;
         emit_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_CITIES; i++) begin
            order_ff[i]      <= CITY_BITS'(i);
            level_ff[i]      <= '0;
            best_order_ff[i] <= '0;
         end
      end else begin
         city_count_ff <= city_count_in;
         load_pos_ff   <= load_pos_in;
         best_cost_ff  <= best_cost_in;
         best_valid_ff <= best_valid_in;
         acc_ff        <= acc_in;
         depth_ff      <= depth_in;
         edge_ff       <= edge_in;
         emit_ff       <= emit_in;
         rd_valid_ff   <= cmd.issue;
         order_ff      <= order_in;
         level_ff      <= level_in;
         best_order_ff <= best_order_in;
      end
   end

   assign rsp_city      = CITY_OUT_BITS'(best_order_ff[emit_ff]);
   assign rsp_tour_cost = TOUR_COST_BITS'(best_cost_ff);
   assign rsp_last_city = status.last_out;

endmodule

`default_nettype wire

/* rtl/core/exhaustive_tour_search.sv */
// Top level of the exhaustive tour search (brute-force travelling salesman).
// Depends on ets_pkg, the channel interfaces, ets_ctrl and ets_datapath.
//
//   channel | direction | beat carries                      | handshake
//   req_if  | in        | distance, last_entry              | valid/ready
//   rsp_if  | out       | city, tour_cost, last_city        | valid/ready
//   csr_if  | in        | city_count                        | valid/ready, ready high
//
// A distance beat is taken every cycle while the block is loading. The beat
// flagged last_entry starts the search, which scores all n! orders: each order
// is scored by n edge reads from the distance memory's single read port, then
// a drain and a compare state, then a walk of the order tree to the next order.
// After the search, n tour beats follow, one per cycle while rsp ready is high;
// a stall on rsp simply holds the current beat. No new distance beat is taken
// until the last tour beat has gone. Reset is synchronous and needs no
// clearing pass; memory entries are only defined once written.
`default_nettype none

module exhaustive_tour_search (
   input  wire      clock,
   input  wire      reset,
   ets_req_if.sink  req_if,
   ets_rsp_if.source rsp_if,
   ets_csr_if.sink  csr_if
);
   import ets_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register always writable; the user must write it only while idle, unchecked.
   assign csr_if.ready = 1'b1;

   // The controller owns the handshakes and walks the order tree.
   ets_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_last_entry (req_if.last_entry),
      .req_ready      (req_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .status         (status),
      .cmd            (cmd)
   );

   // The datapath holds the matrix, the current and best orders and the costs.
   ets_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_distance   (req_if.distance),
      .csr_valid      (csr_if.valid),
      .csr_city_count (csr_if.city_count),
      .rsp_city       (rsp_if.city),
      .rsp_tour_cost  (rsp_if.tour_cost),
      .rsp_last_city  (rsp_if.last_city)
   );

   // Loading and tour output never overlap.
   assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("loading and tour output overlap");

   // The beat that closes the matrix ends loading until the tour has gone out.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.last_entry) |=> !req_if.ready)
      else $error("loading continued after the final matrix entry");

   // Once the final tour beat is taken, the block is ready for a new matrix.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && rsp_if.last_city) |=> req_if.ready)
      else $error("block not back to loading after the tour");

   // Every beat of one tour reports the same cost.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && $past(rsp_if.valid)) |-> $stable(rsp_if.tour_cost))
      else $error("tour cost changed within one tour");

endmodule

`default_nettype wire
